### rtl/irpp_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse pair decoder package
// Shared widths, codes, register layout and result types.
// ----------------------------------------------------------------------------
package irpp_pkg;

    // Tick counter width (8 to 16)
    localparam int TIMER_BITS = 8;

    // Result queue depth and its fill count width
    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Input word kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_EDGE = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_MARKER = 2'd0;
    localparam logic [1:0] KIND_PAIR   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Classified pulse symbols
    localparam logic [1:0] SYM_NONE  = 2'd0;
    localparam logic [1:0] SYM_SHORT = 2'd1;
    localparam logic [1:0] SYM_LONG  = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_SHORT_MIN = 3'd0;
    localparam logic [2:0] REG_SHORT_MAX = 3'd1;
    localparam logic [2:0] REG_LONG_MIN  = 3'd2;
    localparam logic [2:0] REG_LONG_MAX  = 3'd3;
    localparam logic [2:0] REG_GAP_MIN   = 3'd4;
    localparam logic [2:0] REG_GAP_MAX   = 3'd5;
    localparam logic [2:0] REG_FRAME_THR = 3'd6;

    // Register reset values
    localparam logic [7:0] RST_SHORT_MIN = 8'd24;
    localparam logic [7:0] RST_SHORT_MAX = 8'd40;
    localparam logic [7:0] RST_LONG_MIN  = 8'd50;
    localparam logic [7:0] RST_LONG_MAX  = 8'd80;
    localparam logic [7:0] RST_GAP_MIN   = 8'd50;
    localparam logic [7:0] RST_GAP_MAX   = 8'd80;
    localparam logic [7:0] RST_FRAME_THR = 8'd120;

    // Largest reportable error length
    localparam logic [7:0] LEN_SAT = 8'hFF;

    typedef struct packed {
        logic [7:0] short_min;
        logic [7:0] short_max;
        logic [7:0] long_min;
        logic [7:0] long_max;
        logic [7:0] gap_min;
        logic [7:0] gap_max;
        logic [7:0] frame_thr;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       first_value;
        logic       second_value;
        logic [7:0] bad_length;
        logic       last;
    } result_t;

    // Results produced by one input word, oldest in res0
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    // Sort a pulse length into short, long or neither; short wins
    function automatic logic [1:0] classify(input logic [TIMER_BITS-1:0] len,
                                            input cfg_t cfg);
        logic [1:0] sym;
        sym = SYM_NONE;
        if (len >= TIMER_BITS'(cfg.short_min) && len <= TIMER_BITS'(cfg.short_max)) begin
            sym = SYM_SHORT;
        end else if (len >= TIMER_BITS'(cfg.long_min) &&
                     len <= TIMER_BITS'(cfg.long_max)) begin
            sym = SYM_LONG;
        end
        return sym;
    endfunction

endpackage

### rtl/irpp_cfg_regs.sv
// ----------------------------------------------------------------------------
// IR pulse pair decoder configuration registers
// Holds the window limits and frame threshold written over the config port.
// ----------------------------------------------------------------------------
module irpp_cfg_regs import irpp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  logic [2:0] wr_index,
    input  logic [7:0] wr_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_SHORT_MIN: cfg_next.short_min = wr_data;
                REG_SHORT_MAX: cfg_next.short_max = wr_data;
                REG_LONG_MIN:  cfg_next.long_min  = wr_data;
                REG_LONG_MAX:  cfg_next.long_max  = wr_data;
                REG_GAP_MIN:   cfg_next.gap_min   = wr_data;
                REG_GAP_MAX:   cfg_next.gap_max   = wr_data;
                REG_FRAME_THR: cfg_next.frame_thr = wr_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_min <= RST_SHORT_MIN;
            cfg_reg.short_max <= RST_SHORT_MAX;
            cfg_reg.long_min  <= RST_LONG_MIN;
            cfg_reg.long_max  <= RST_LONG_MAX;
            cfg_reg.gap_min   <= RST_GAP_MIN;
            cfg_reg.gap_max   <= RST_GAP_MAX;
            cfg_reg.frame_thr <= RST_FRAME_THR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/irpp_decode.sv
// ----------------------------------------------------------------------------
// IR pulse pair decoder core
// Tick counter, pulse and pair state; turns each accepted word into results.
// ----------------------------------------------------------------------------
module irpp_decode import irpp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_accept,
    input  logic  in_cmd,
    input  logic  in_level,
    input  cfg_t  cfg,
    output push_t push
);

    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [TIMER_BITS-1:0] gap_start_reg, gap_start_next;
    logic                  open_reg, open_next;
    logic [1:0]            first_reg, first_next;

    logic signed [TIMER_BITS:0] gap;
    logic signed [TIMER_BITS:0] gap_lo;
    logic signed [TIMER_BITS:0] gap_hi;
    logic [1:0]                 sym;
    logic                       marker;
    logic                       pair_out;
    logic [7:0]                 err_len;
    result_t                    marker_res;
    result_t                    pair_res;

    // Signed gap since the last rise, and the length classification
    assign gap    = $signed({1'b0, tick_reg}) - $signed({1'b0, gap_start_reg});
    assign gap_lo = $signed({1'b0, TIMER_BITS'(cfg.gap_min)});
    assign gap_hi = $signed({1'b0, TIMER_BITS'(cfg.gap_max)});
    assign sym    = classify(tick_reg, cfg);
    assign err_len = (tick_reg > TIMER_BITS'(LEN_SAT)) ? LEN_SAT : tick_reg[7:0];

    // Candidate results for a closing pulse
    always_comb begin
        marker_res              = '0;
        marker_res.kind         = KIND_MARKER;
        pair_res                = '0;
        if (sym != SYM_NONE) begin
            pair_res.kind         = KIND_PAIR;
            pair_res.first_value  = (first_reg == SYM_LONG);
            pair_res.second_value = (sym == SYM_LONG);
        end else begin
            pair_res.kind       = KIND_ERROR;
            pair_res.bad_length = err_len;
        end
    end

    // Advance state and collect results for the accepted word
    always_comb begin
        tick_next      = tick_reg;
        gap_start_next = gap_start_reg;
        open_next      = open_reg;
        first_next     = first_reg;
        marker         = 1'b0;
        pair_out       = 1'b0;
        if (in_accept) begin
            if (in_cmd == CMD_TICK) begin
                tick_next = tick_reg + TIMER_BITS'(1);
            end else if (!in_level) begin
                // falling edge opens a pulse; a bad gap drops the held bit
                if (!open_reg) begin
                    tick_next = '0;
                    open_next = 1'b1;
                    if (first_reg != SYM_NONE && !(gap >= gap_lo && gap <= gap_hi)) begin
                        first_next = SYM_NONE;
                    end
                end
            end else if (open_reg) begin
                // rising edge closes the pulse
                open_next      = 1'b0;
                gap_start_next = tick_reg;
                marker         = (tick_reg > TIMER_BITS'(cfg.frame_thr));
                if (first_reg == SYM_NONE) begin
                    first_next = sym;
                end else begin
                    pair_out   = 1'b1;
                    first_next = SYM_NONE;
                end
            end
        end
    end

    // Order results: marker first, last flag on the final one
    always_comb begin
        push.count = {1'b0, marker} + {1'b0, pair_out};
        push.res0  = marker ? marker_res : pair_res;
        push.res1  = pair_res;
        push.res0.last = !(marker && pair_out);
        push.res1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            gap_start_reg <= '0;
            open_reg      <= 1'b0;
            first_reg     <= SYM_NONE;
        end else begin
            tick_reg      <= tick_next;
            gap_start_reg <= gap_start_next;
            open_reg      <= open_next;
            first_reg     <= first_next;
        end
    end

endmodule

### rtl/irpp_out_queue.sv
// ----------------------------------------------------------------------------
// IR pulse pair decoder result queue
// Shifting result buffer: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module irpp_out_queue import irpp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_head,
    output logic    has_room
);

    result_t            slot_reg  [QUEUE_DEPTH];
    result_t            slot_next [QUEUE_DEPTH];
    result_t            shifted   [QUEUE_DEPTH];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   base;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_head  = slot_reg[0];
    assign has_room  = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign pop       = out_valid && out_ready;
    assign base      = count_reg - CNT_W'(pop);

    // Contents after a pop
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            shifted[i] = slot_reg[i + 1];
        end
        shifted[QUEUE_DEPTH-1] = slot_reg[QUEUE_DEPTH-1];
    end

    // Shift out the head and append new results behind the survivors
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (CNT_W'(i) < base) begin
                slot_next[i] = pop ? shifted[i] : slot_reg[i];
            end else if (CNT_W'(i) == base && push.count != 2'd0) begin
                slot_next[i] = push.res0;
            end else if (CNT_W'(i) == base + CNT_W'(1) && push.count == 2'd2) begin
                slot_next[i] = push.res1;
            end else begin
                slot_next[i] = slot_reg[i];
            end
        end
        count_next = base + CNT_W'(push.count);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

### rtl/ir_pulse_pair_decoder.sv
// Results are registered in the queue when their edge word is accepted; m_ offers the queue head.
// Throughput: one input word per cycle while s_tready is high; the decode state updates in the accept cycle.
// s_tready drops while the four-entry result queue holds more than two words.
// Reset (aresetn low, synchronous): counter, pulse and pair state cleared, queue emptied,
// registers back to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
// IR pulse pair decoder
// Decodes an active-low IR pulse train of ticks and edges into bit pairs.
// ----------------------------------------------------------------------------
module ir_pulse_pair_decoder import irpp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] line_level, [7:1] zero
    input  logic        s_tuser,   // [0] cmd
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] first_value, [1] second_value,
                                   // [9:2] bad_length, [15:10] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t    cfg;
    push_t   dec_push;
    result_t head;
    logic    in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    irpp_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    irpp_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_cmd    (s_tuser),
        .in_level  (s_tdata[0]),
        .cfg       (cfg),
        .push      (dec_push)
    );

    irpp_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (dec_push),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_head  (head),
        .has_room  (s_tready)
    );

    // Pack the head result onto the stream
    assign m_tdata = {6'b0, head.bad_length, head.second_value, head.first_value};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

`ifndef SYNTHESIS
    // input is refused only while results are waiting
    assert property (@(posedge aclk) disable iff (!aresetn) !s_tready |-> m_tvalid)
        else $error("input stalled with an empty result queue");

    // results come only from an accepted edge word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_push.count != 2'd0) |-> (in_accept && s_tuser == CMD_EDGE))
        else $error("result pushed without an accepted edge");

    // two results: marker first, last flag only on the second
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_push.count == 2'd2) |->
            (dec_push.res0.kind == KIND_MARKER && !dec_push.res0.last && dec_push.res1.last))
        else $error("bad ordering of a two-result word");

    // after a push, the output offers a result the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_push.count != 2'd0) |=> m_tvalid)
        else $error("pushed result not offered");
`endif

endmodule
